### src/lis_pkg.sv
// Package for the longest increasing subsequence unit: sizes, payload types,
// the store entry layout and the controller state type. No dependencies.
package lis_pkg;

   localparam int MAX_ITEMS = 1024;
   localparam int ADDR_W    = $clog2(MAX_ITEMS);
   localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
   localparam int LEN_W     = CNT_W;
   localparam int OUT_LEN_W = 11;

   typedef struct packed {
      logic signed [31:0] value;
      logic               last;
   } req_type;

   typedef struct packed {
      logic [OUT_LEN_W-1:0] len_ending_here;
      logic [OUT_LEN_W-1:0] best_len;
      logic                 dropped;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic [LEN_W-1:0]   len;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic               start;
      logic signed [31:0] value;
      logic [CNT_W-1:0]   count;
   } scan_req_type;

   typedef struct packed {
      logic             done;
      logic [LEN_W-1:0] longest;
   } scan_rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

endpackage

### src/lis_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module lis_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/lis_scan.sv
// Scan unit: walks the stored entries of the current sequence, one read a
// cycle, and keeps the greatest length among strictly smaller values.
// Depends on lis_pkg.
module lis_scan
   import lis_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  scan_req_type      scan_req,
   output scan_rsp_type      scan_rsp,
   output logic [ADDR_W-1:0] rd_addr,
   input  logic [ENTRY_W-1:0] rd_data
);

   logic               busy_ff, busy_in;
   logic               pend_ff, pend_in;
   logic [CNT_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic signed [31:0] value_ff, value_in;
   logic [LEN_W-1:0]   max_ff, max_in;
   logic               issue;
   logic               done;
   entry_type          entry;

   assign entry   = entry_type'(rd_data);
   assign issue   = busy_ff && (idx_ff != count_ff);
   assign done    = busy_ff && !issue && !pend_ff;
   assign rd_addr = idx_ff[ADDR_W-1:0];

   always_comb begin
      busy_in  = busy_ff;
      pend_in  = issue;
      idx_in   = idx_ff;
      count_in = count_ff;
      value_in = value_ff;
      max_in   = max_ff;
      if (pend_ff && (entry.value < value_ff) && (entry.len > max_ff)) begin
         max_in = entry.len;
      end
      if (issue) begin
         idx_in = idx_ff + CNT_W'(1);
      end
      if (done) begin
         busy_in = 1'b0;
      end
      if (scan_req.start) begin
         busy_in  = 1'b1;
         pend_in  = 1'b0;
         idx_in   = '0;
         count_in = scan_req.count;
         value_in = scan_req.value;
         max_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pend_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pend_ff <= pend_in;
      end
      idx_ff   <= idx_in;
      count_ff <= count_in;
      value_ff <= value_in;
      max_ff   <= max_in;
   end

   assign scan_rsp.done    = done;
   assign scan_rsp.longest = max_ff;

endmodule

### src/longest_increasing_subsequence_unit.sv
// Longest strictly increasing subsequence unit over a stream of signed values.
// The scan reads one stored entry a cycle from a single RAM port; an item that
// arrives with the store full skips the scan and is dropped. A result waits in
// an output register while the next request is taken. Synchronous reset clears
// the count, the best length and all handshake state; the store is not cleared.
module longest_increasing_subsequence_unit
   import lis_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [LEN_W-1:0]   best_ff, best_in;
   logic signed [31:0] value_ff;
   logic               last_ff;
   logic               drop_ff;
   logic [LEN_W-1:0]   here_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff;
   logic               req_xfer;
   logic               full;
   logic               slot_free;
   logic               start_scan;
   logic               commit;
   logic               wr_en;
   logic [LEN_W-1:0]   best_new;
   scan_req_type       scan_req;
   scan_rsp_type       scan_rsp;
   logic [ADDR_W-1:0]  rd_addr;
   logic [ENTRY_W-1:0] rd_data;
   entry_type          wr_entry;

   assign req_xfer  = req_valid && req_ready;
   assign full      = (count_ff == CNT_W'(MAX_ITEMS));
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign best_new  = (here_ff > best_ff) ? here_ff : best_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = full ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_rsp.done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      start_scan = 1'b0;
      commit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            start_scan = req_valid && !full;
         end
         ST_SCAN: begin
         end
         ST_FINISH: begin
            commit = slot_free;
         end
         default: begin
         end
      endcase
   end

   assign wr_en = commit && !drop_ff;

   assign scan_req.start = start_scan;
   assign scan_req.value = req_data.value;
   assign scan_req.count = count_ff;

   assign wr_entry.value = value_ff;
   assign wr_entry.len   = here_ff;

   always_comb begin
      count_in     = count_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (commit) begin
         rsp_valid_in = 1'b1;
         if (!drop_ff) begin
            count_in = count_ff + CNT_W'(1);
            best_in  = best_new;
         end
         if (last_ff) begin
            count_in = '0;
            best_in  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         best_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         best_ff      <= best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_xfer) begin
         value_ff <= req_data.value;
         last_ff  <= req_data.last;
         drop_ff  <= full;
         here_ff  <= '0;
      end
      if (state_ff == ST_SCAN && scan_rsp.done) begin
         here_ff <= scan_rsp.longest + LEN_W'(1);
      end
      if (commit) begin
         rsp_data_ff.dropped <= drop_ff;
         if (drop_ff) begin
            rsp_data_ff.len_ending_here <= '0;
            rsp_data_ff.best_len        <= OUT_LEN_W'(best_ff);
         end else begin
            rsp_data_ff.len_ending_here <= OUT_LEN_W'(here_ff);
            rsp_data_ff.best_len        <= OUT_LEN_W'(best_new);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   lis_scan u_scan (
      .clock    (clock),
      .reset    (reset),
      .scan_req (scan_req),
      .scan_rsp (scan_rsp),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data)
   );

   lis_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_ITEMS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for longest_increasing_subsequence_unit: random and directed
// value sequences with an in-bench length predictor. Depends on lis_pkg and the unit.
module tb;
   import lis_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 4_000_000;
   localparam int unsigned SETTLE_CYCLES = MAX_ITEMS + 80;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned HOLD_AFTER = 40;
   localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] VALUE_HALF_MIN = -32'sd1073741824;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   req_type     req_backlog[$];
   rsp_type     pending_lengths[$];
   int unsigned send_idle_pct = 32;
   int unsigned recv_idle_pct = 65;
   logic        req_accepted = 1'b0;
   int unsigned items_taken = 0;
   int unsigned results_seen = 0;
   int unsigned dropped_seen = 0;
   int unsigned peak_best = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_left = 0;
   logic        hold_used = 1'b0;

   logic signed [31:0] seq_value[MAX_ITEMS];
   int unsigned        seq_len[MAX_ITEMS];
   int unsigned        seq_count = 0;
   int unsigned        seq_best = 0;

   longest_increasing_subsequence_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type next_lengths(req_type item);
      rsp_type     res;
      int unsigned longest;
      int unsigned here;
      res = '0;
      here = 0;
      if (seq_count >= MAX_ITEMS) begin
         res.dropped = 1'b1;
      end else begin
         longest = 0;
         for (int unsigned i = 0; i < seq_count; i++) begin
            if ($signed(seq_value[i]) < $signed(item.value) && seq_len[i] > longest) begin
               longest = seq_len[i];
            end
         end
         here = longest + 1;
         seq_value[seq_count] = item.value;
         seq_len[seq_count] = here;
         seq_count++;
         if (here > seq_best) begin
            seq_best = here;
         end
      end
      res.len_ending_here = OUT_LEN_W'(here);
      res.best_len = OUT_LEN_W'(seq_best);
      if (item.last) begin
         seq_count = 0;
         seq_best = 0;
      end
      return res;
   endfunction

   task automatic add_item(logic signed [31:0] v, logic last);
      req_type item;
      item.value = v;
      item.last = last;
      req_backlog.push_back(item);
   endtask

   task automatic add_random_sequences(int unsigned n_items);
      int unsigned        added;
      int unsigned        len;
      int unsigned        style;
      int unsigned        pick;
      int                 step;
      int                 i;
      logic signed [31:0] base;
      logic signed [31:0] v;
      added = 0;
      while (added < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            len = $urandom_range(1, 12);
         end else if (pick < 95) begin
            len = $urandom_range(13, 60);
         end else begin
            len = $urandom_range(61, 150);
         end
         if (len > n_items - added) begin
            len = n_items - added;
         end
         style = $urandom_range(0, 3);
         base = $urandom;
         step = int'($urandom_range(0, 2000)) - 500;
         for (i = 0; i < int'(len); i++) begin
            case (style)
               0: begin
                  v = $urandom;
               end
               1: begin
                  v = int'($urandom_range(0, 16)) - 8;
               end
               2: begin
                  v = base + i * step + int'($urandom_range(0, 1500));
               end
               default: begin
                  case ($urandom_range(0, 6))
                     0: v = VALUE_MIN;
                     1: v = VALUE_MAX;
                     2: v = VALUE_HALF_MIN;
                     3: v = 0;
                     4: v = -1;
                     5: v = VALUE_MIN + int'($urandom_range(0, 3));
                     default: v = VALUE_MAX - int'($urandom_range(0, 3));
                  endcase
               end
            endcase
            add_item(v, i == int'(len) - 1);
         end
         added += len;
      end
   endtask

   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_valid || pending_lengths.size() != 0) begin
         @(negedge clock);
      end
      @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_accepted) begin
         if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= req_backlog.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= !reset && hold_left == 0 && $urandom_range(0, 99) >= recv_idle_pct;
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_used && items_taken == HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_used <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin : monitor
      rsp_type expected;
      if (reset) begin
         req_accepted <= 1'b0;
      end else begin
         req_accepted <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            pending_lengths.push_back(next_lengths(req_data));
            items_taken <= items_taken + 1;
         end
         if (rsp_valid && rsp_ready) begin
            results_seen <= results_seen + 1;
            if (rsp_data.dropped) begin
               dropped_seen <= dropped_seen + 1;
            end
            if (rsp_data.best_len > peak_best) begin
               peak_best <= 32'(rsp_data.best_len);
            end
            if (pending_lengths.size() == 0) begin
               if (error_count < 10) begin
                  $display("tb: unexpected result len %0d best %0d dropped %0d",
                           rsp_data.len_ending_here, rsp_data.best_len, rsp_data.dropped);
               end
               error_count <= error_count + 1;
            end else begin
               expected = pending_lengths.pop_front();
               if (rsp_data.len_ending_here !== expected.len_ending_here ||
                   rsp_data.best_len !== expected.best_len ||
                   rsp_data.dropped !== expected.dropped) begin
                  if (error_count < 10) begin
                     $display("tb: mismatch at result %0d: len %0d/%0d best %0d/%0d drop %0d/%0d",
                              results_seen, expected.len_ending_here, rsp_data.len_ending_here,
                              expected.best_len, rsp_data.best_len,
                              expected.dropped, rsp_data.dropped);
                  end
                  error_count <= error_count + 1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   initial begin
      add_item(VALUE_MIN, 1'b0);
      add_item(VALUE_MAX, 1'b1);
      add_item(5, 1'b0);
      add_item(5, 1'b0);
      add_item(5, 1'b1);
      add_item(7, 1'b1);
      add_item(3, 1'b0);
      add_item(2, 1'b0);
      add_item(1, 1'b1);
      add_item(VALUE_HALF_MIN - 1, 1'b0);
      add_item(VALUE_HALF_MIN, 1'b0);
      add_item(VALUE_HALF_MIN, 1'b1);
      add_item(10, 1'b0);
      add_item(9, 1'b0);
      add_item(2, 1'b0);
      add_item(5, 1'b0);
      add_item(3, 1'b0);
      add_item(7, 1'b0);
      add_item(101, 1'b0);
      add_item(18, 1'b1);
      add_item(VALUE_MAX, 1'b0);
      add_item(VALUE_MIN, 1'b0);
      add_item(0, 1'b0);
      add_item(-1, 1'b0);
      add_item(1, 1'b1);
      add_random_sequences(180);
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      wait_drained();
      send_idle_pct = 65;
      recv_idle_pct = 32;
      add_random_sequences(185);

      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_sequences(185);
      add_item(-4, 1'b0);
      add_item(-9, 1'b0);
      add_item(6, 1'b1);

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("tb: %0d requests taken, %0d results checked under three pacing phases",
               items_taken, results_seen);
      $display("tb: %0d dropped results, longest run length %0d, %0d errors",
               dropped_seen, peak_best, error_count);
      if (error_count == 0 && pending_lengths.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

### filelist.f
src/lis_pkg.sv
src/lis_ram.sv
src/lis_scan.sv
src/longest_increasing_subsequence_unit.sv
dv/tb.sv
